### rtl/kfs_pkg.sv
// Shared types and constants for the key feature selector.
// No dependencies; every other file imports this package.
package kfs_pkg;

	localparam int FRAC_BITS   = 4;
	localparam int ID_BITS     = 16;
	localparam int NUM_SLOTS   = 5;
	localparam int SLOT_W      = 3;
	localparam int COORD_W     = 16;
	localparam int FIELD_ID_W  = 16;
	localparam int CMD_W       = 2;
	localparam int MASK_W      = NUM_SLOTS;
	localparam int CFG_W       = 13;
	localparam int CFG_IDX_W   = 1;
	localparam int QUEUE_DEPTH = 2;

	// id bits actually kept per slot
	localparam int ID_W    = (ID_BITS < FIELD_ID_W) ? ID_BITS : FIELD_ID_W;
	// centre coordinate: half of a CFG_W size, scaled to fixed point
	localparam int CTR_W   = CFG_W - 1 + FRAC_BITS;
	localparam int DIFF_W  = ((CTR_W > COORD_W) ? CTR_W : COORD_W) + 1;
	localparam int DIST_W  = DIFF_W - 1;
	localparam int PROD_W  = 2 * DIFF_W;

	localparam int RESET_WIDTH  = 640;
	localparam int RESET_HEIGHT = 480;

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

	typedef logic [SLOT_W-1:0] slot_idx_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_OFFER  = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 1'd0,
		REG_IMAGE_HEIGHT = 1'd1
	} cfg_reg_t;

	// Quadrant slot codes
	localparam slot_idx_t SLOT_CENTER = 3'd0;
	localparam slot_idx_t SLOT_XP_YP  = 3'd1;
	localparam slot_idx_t SLOT_XP_YN  = 3'd2;
	localparam slot_idx_t SLOT_XN_YN  = 3'd3;
	localparam slot_idx_t SLOT_XN_YP  = 3'd4;

	// All five slots as they stand after one item
	typedef struct packed {
		logic [MASK_W-1:0]                     mask;
		logic [NUM_SLOTS-1:0]                  valid;
		logic [NUM_SLOTS-1:0][FIELD_ID_W-1:0]  id;
		logic [NUM_SLOTS-1:0][COORD_W-1:0]     x;
		logic [NUM_SLOTS-1:0][COORD_W-1:0]     y;
	} snap_t;

endpackage

### rtl/kfs_in_if.sv
// Input item channel: valid/ready plus command payload.
// Depends on kfs_pkg.
interface kfs_in_if import kfs_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CMD_W-1:0]      command;
	logic [COORD_W-1:0]    pos_x;
	logic [COORD_W-1:0]    pos_y;
	logic [FIELD_ID_W-1:0] feature_id;
	logic                  has_map_point;

	modport source (output valid, command, pos_x, pos_y, feature_id, has_map_point,
		input ready);
	modport sink (input valid, command, pos_x, pos_y, feature_id, has_map_point,
		output ready);
endinterface

### rtl/kfs_out_if.sv
// Result channel: valid/ready plus one slot report per beat.
// Depends on kfs_pkg.
interface kfs_out_if import kfs_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [SLOT_W-1:0]     slot_index;
	logic                  slot_valid;
	logic [FIELD_ID_W-1:0] slot_feature;
	logic [COORD_W-1:0]    slot_x;
	logic [COORD_W-1:0]    slot_y;
	logic [MASK_W-1:0]     changed_mask;
	logic                  last;

	modport source (output valid, slot_index, slot_valid, slot_feature, slot_x, slot_y,
		changed_mask, last, input ready);
	modport sink (input valid, slot_index, slot_valid, slot_feature, slot_x, slot_y,
		changed_mask, last, output ready);
endinterface

### rtl/kfs_cfg_if.sv
// Configuration write channel: valid/ready, register index and data.
// Depends on kfs_pkg.
interface kfs_cfg_if import kfs_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### rtl/kfs_front.sv
// Front end: input stage, centre registers, slot state and update logic.
// Depends on kfs_pkg, kfs_in_if, kfs_cfg_if; pushes snapshots into kfs_queue.
module kfs_front import kfs_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	kfs_in_if.sink       item,
	kfs_cfg_if.sink      cfg,
	input  logic         full,
	output logic         push,
	output snap_t        push_data
);

	// centre registers
	logic [CTR_W-1:0] cx_q, cy_q;

	// stage 1
	logic                    valid_s1;
	cmd_t                    cmd_s1;
	logic [COORD_W-1:0]      x_s1, y_s1;
	logic [ID_W-1:0]         id_s1;
	logic                    mp_s1;
	slot_idx_t               q_s1;
	logic signed [PROD_W-1:0] prod_s1;
	logic [DIST_W-1:0]       cheb_s1;

	// slot state
	logic [NUM_SLOTS-1:0] held_valid_q;
	logic [COORD_W-1:0]   held_x_q  [NUM_SLOTS];
	logic [COORD_W-1:0]   held_y_q  [NUM_SLOTS];
	logic [ID_W-1:0]      held_id_q [NUM_SLOTS];

	logic                     load_s1;
	logic signed [DIFF_W-1:0] dx_n, dy_n;
	logic [DIST_W-1:0]        adx_n, ady_n;

	logic signed [DIFF_W-1:0] hdx, hdy, h0dx, h0dy;
	logic [DIST_W-1:0]        h0adx, h0ady, h0cheb;
	logic signed [PROD_W-1:0] hprod;
	logic                     take0, takeq;

	logic [NUM_SLOTS-1:0] nv;
	logic [COORD_W-1:0]   nx  [NUM_SLOTS];
	logic [COORD_W-1:0]   ny  [NUM_SLOTS];
	logic [ID_W-1:0]      nid [NUM_SLOTS];
	logic [MASK_W-1:0]    nmask;

	assign cfg.ready  = 1'b1;
	assign push       = valid_s1 && !full;
	assign item.ready = !valid_s1 || !full;
	assign load_s1    = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= CTR_W'(RESET_WIDTH / 2) << FRAC_BITS;
			cy_q <= CTR_W'(RESET_HEIGHT / 2) << FRAC_BITS;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_IMAGE_WIDTH:  cx_q <= CTR_W'(cfg.data[CFG_W-1:1]) << FRAC_BITS;
				REG_IMAGE_HEIGHT: cy_q <= CTR_W'(cfg.data[CFG_W-1:1]) << FRAC_BITS;
				default: ;
			endcase
		end
	end

	// stage 1: offsets from centre, quadrant, product and Chebyshev distance
	always_comb begin
		dx_n  = $signed(DIFF_W'(item.pos_x)) - $signed(DIFF_W'(cx_q));
		dy_n  = $signed(DIFF_W'(item.pos_y)) - $signed(DIFF_W'(cy_q));
		adx_n = dx_n[DIFF_W-1] ? DIST_W'(-dx_n) : DIST_W'(dx_n);
		ady_n = dy_n[DIFF_W-1] ? DIST_W'(-dy_n) : DIST_W'(dy_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			cmd_s1  <= cmd_t'(item.command);
			x_s1    <= item.pos_x;
			y_s1    <= item.pos_y;
			id_s1   <= item.feature_id[ID_W-1:0];
			mp_s1   <= item.has_map_point;
			prod_s1 <= PROD_W'(dx_n) * PROD_W'(dy_n);
			cheb_s1 <= (adx_n > ady_n) ? adx_n : ady_n;
			if (!dx_n[DIFF_W-1])
				q_s1 <= dy_n[DIFF_W-1] ? SLOT_XP_YN : SLOT_XP_YP;
			else
				q_s1 <= dy_n[DIFF_W-1] ? SLOT_XN_YN : SLOT_XN_YP;
		end
	end

	// stage 2: compare against held slots and commit
	always_comb begin
		hdx    = $signed(DIFF_W'(held_x_q[q_s1])) - $signed(DIFF_W'(cx_q));
		hdy    = $signed(DIFF_W'(held_y_q[q_s1])) - $signed(DIFF_W'(cy_q));
		hprod  = PROD_W'(hdx) * PROD_W'(hdy);
		h0dx   = $signed(DIFF_W'(held_x_q[0])) - $signed(DIFF_W'(cx_q));
		h0dy   = $signed(DIFF_W'(held_y_q[0])) - $signed(DIFF_W'(cy_q));
		h0adx  = h0dx[DIFF_W-1] ? DIST_W'(-h0dx) : DIST_W'(h0dx);
		h0ady  = h0dy[DIFF_W-1] ? DIST_W'(-h0dy) : DIST_W'(h0dy);
		h0cheb = (h0adx > h0ady) ? h0adx : h0ady;
		take0  = !held_valid_q[0] || (cheb_s1 < h0cheb);
		takeq  = !held_valid_q[q_s1] || (prod_s1 > hprod);
	end

	always_comb begin
		for (int k = 0; k < NUM_SLOTS; k++) begin
			nv[k]  = held_valid_q[k];
			nx[k]  = held_x_q[k];
			ny[k]  = held_y_q[k];
			nid[k] = held_id_q[k];
			case (cmd_s1)
				CMD_CLEAR: nv[k] = 1'b0;
				CMD_OFFER: begin
					if (mp_s1 && (((SLOT_W'(k) == SLOT_CENTER) && take0) ||
						((SLOT_W'(k) == q_s1) && takeq))) begin
						nv[k]  = 1'b1;
						nx[k]  = x_s1;
						ny[k]  = y_s1;
						nid[k] = id_s1;
					end
				end
				CMD_REMOVE: begin
					if (held_valid_q[k] && (held_id_q[k] == id_s1))
						nv[k] = 1'b0;
				end
				default: ;
			endcase
			nmask[k] = (nv[k] != held_valid_q[k]) ||
				(nv[k] && ((nx[k] != held_x_q[k]) || (ny[k] != held_y_q[k]) ||
				(nid[k] != held_id_q[k])));
			push_data.valid[k] = nv[k];
			push_data.x[k]     = nx[k];
			push_data.y[k]     = ny[k];
			push_data.id[k]    = FIELD_ID_W'(nid[k]);
		end
		push_data.mask = nmask;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= '0;
		end else if (push) begin
			held_valid_q <= nv;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			for (int k = 0; k < NUM_SLOTS; k++) begin
				held_x_q[k]  <= nx[k];
				held_y_q[k]  <= ny[k];
				held_id_q[k] <= nid[k];
			end
		end
	end

`ifndef SYNTHESIS
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		push && (cmd_s1 == CMD_CLEAR) |=> held_valid_q == '0)
		else $error("slots not empty after clear");
	a_read_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		push && (cmd_s1 == CMD_READ) |-> push_data.mask == '0 && nv == held_valid_q)
		else $error("read command changed slot state");
`endif

endmodule

### rtl/kfs_queue.sv
// Short snapshot queue between the update front end and the result serializer.
// Depends on kfs_pkg (snap_t, QUEUE_DEPTH).
module kfs_queue import kfs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  snap_t push_data,
	output logic  full,
	input  logic  pop,
	output snap_t head,
	output logic  empty
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	snap_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

`ifndef SYNTHESIS
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> !full)
		else $error("snapshot queue overrun");
`endif

endmodule

### rtl/kfs_back.sv
// Back end: walks one snapshot out as five slot beats through an output register.
// Depends on kfs_pkg and kfs_out_if; reads the head of kfs_queue.
module kfs_back import kfs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  snap_t     head,
	input  logic      empty,
	output logic      pop,
	kfs_out_if.source result
);

	slot_idx_t             beat_q;
	logic                  out_valid_q;
	slot_idx_t             idx_q;
	logic                  sv_q;
	logic [FIELD_ID_W-1:0] id_q;
	logic [COORD_W-1:0]    x_q, y_q;
	logic [MASK_W-1:0]     mask_q;
	logic                  last_q;
	logic                  load;
	logic                  sv_n;

	assign load = !empty && (!out_valid_q || result.ready);
	assign pop  = load && (beat_q == LAST_SLOT);
	assign sv_n = head.valid[beat_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				beat_q <= (beat_q == LAST_SLOT) ? '0 : beat_q + 1'b1;
			if (load)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
		end
	end

	// empty slots report zeros
	always_ff @(posedge clk) begin
		if (load) begin
			idx_q  <= beat_q;
			sv_q   <= sv_n;
			id_q   <= sv_n ? head.id[beat_q] : '0;
			x_q    <= sv_n ? head.x[beat_q] : '0;
			y_q    <= sv_n ? head.y[beat_q] : '0;
			mask_q <= head.mask;
			last_q <= (beat_q == LAST_SLOT);
		end
	end

	assign result.valid        = out_valid_q;
	assign result.slot_index   = idx_q;
	assign result.slot_valid   = sv_q;
	assign result.slot_feature = id_q;
	assign result.slot_x       = x_q;
	assign result.slot_y       = y_q;
	assign result.changed_mask = mask_q;
	assign result.last         = last_q;

`ifndef SYNTHESIS
	a_pop_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid_q && last_q && (idx_q == LAST_SLOT))
		else $error("snapshot released without its final beat");
`endif

endmodule

### rtl/key_feature_selector.sv
// Key feature selector, top level: front end, snapshot queue, result serializer.
// Path: item register (stage 1), slot update and queue push, then the output register.
// Flow: input beats are taken back to back until the two-entry queue fills;
// after that, each item waits for the five result beats of the item before it.
// Reset (arst_n, async, active low): all slots empty, centre at 320,240 px, no beats.
// Depends on kfs_pkg, kfs_in_if, kfs_out_if, kfs_cfg_if, kfs_front, kfs_queue, kfs_back.
module key_feature_selector import kfs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	kfs_in_if.sink    item,
	kfs_out_if.source result,
	kfs_cfg_if.sink   cfg
);

	// front -> queue
	logic  push, full;
	snap_t push_data;

	// queue -> back
	logic  pop, empty;
	snap_t head;

	// Front: registers the item (coordinates, quadrant, product, distance),
	// then updates the five slots and pushes the new slot picture.
	kfs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg       (cfg),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	// Decouples slot updates from result draining.
	kfs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	// Back: five beats per snapshot, slot 0 first, last on slot 4.
	kfs_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

endmodule
